// ===== rtl/lbnt_pkg.sv =====
`timescale 1ns / 1ps

package lbnt_pkg;

   localparam int CHANNELS = 8;
   localparam int AVG_LOG2 = 6;
   localparam int SCALES   = 2;

   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 10;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int MARGIN_W = 8;
   localparam int CSR_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam int CH_SLOTS = 1 << CH_W;
   localparam int NCH      = (CHANNELS < CH_SLOTS) ? CHANNELS : CH_SLOTS;
   localparam int BTN_W    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int CNT_W    = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
   localparam int SUM_W    = SAMPLE_W + AVG_LOG2;
   localparam int SCALE_W  = (SCALES > 1) ? $clog2(SCALES) : 1;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam int RSP_NOTE_LSB = 0;
   localparam int RSP_VEL_LSB  = RSP_NOTE_LSB + NOTE_W;
   localparam int RSP_CH_LSB   = RSP_VEL_LSB + VEL_W;
   localparam int RSP_USED_W   = RSP_CH_LSB + CH_W;

   localparam int REQ_CH_LSB     = 0;
   localparam int REQ_SAMPLE_LSB = REQ_CH_LSB + CH_W;
   localparam int REQ_USED_W     = REQ_SAMPLE_LSB + SAMPLE_W;

   localparam logic [NOTE_W-1:0]   BASE_NOTE_RST  = 7'd60;
   localparam logic [VEL_W-1:0]    VELOCITY_RST   = 7'd100;
   localparam logic [MARGIN_W-1:0] PRESS_MARG_RST = 8'd50;
   localparam logic [MARGIN_W-1:0] RECAL_MARG_RST = 8'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_NOTE    = 2'd0,
      CSR_VELOCITY     = 2'd1,
      CSR_PRESS_MARGIN = 2'd2,
      CSR_RECAL_MARGIN = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_NOTE_OFF = 1'b0,
      KIND_NOTE_ON  = 1'b1
   } note_kind_type;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_BUTTON = 1'b1
   } func_type;

   typedef struct packed {
      logic note_off;
      logic recal;
      logic note_on;
   } action_type;

   localparam logic [3:0] SCALE_TABLE [2][8] = '{
      '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd12},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}
   };

   function automatic logic [NOTE_W-1:0] note_of(
      input logic [NOTE_W-1:0]  base,
      input logic [SCALE_W-1:0] scale,
      input logic [CH_W-1:0]    ch
   );
      logic [3:0]      ofs;
      logic [NOTE_W:0] sum;
      ofs = SCALE_TABLE[scale[0]][ch];
      sum = {1'b0, base} + {{(NOTE_W - 3){1'b0}}, ofs};
      return sum[NOTE_W] ? {NOTE_W{1'b1}} : sum[NOTE_W-1:0];
   endfunction

endpackage

// ===== rtl/lbnt_decide.sv =====
`timescale 1ns / 1ps

module lbnt_decide (
   input  logic [lbnt_pkg::SAMPLE_W-1:0] sample,
   input  logic [lbnt_pkg::SAMPLE_W-1:0] baseline,
   input  logic                          note_active,
   input  logic [lbnt_pkg::MARGIN_W-1:0] press_margin,
   input  logic [lbnt_pkg::MARGIN_W-1:0] recal_margin,
   output lbnt_pkg::action_type          action
);

   localparam int PAD = lbnt_pkg::SAMPLE_W - lbnt_pkg::MARGIN_W + 1;

   logic above_base;
   logic above_recal;
   logic below_press;

   always_comb begin
      above_base  = sample > baseline;
      above_recal = {1'b0, sample} > ({1'b0, baseline} + {{PAD{1'b0}}, recal_margin});
      below_press = ({1'b0, sample} + {{PAD{1'b0}}, press_margin}) < {1'b0, baseline};

      action.note_off = note_active && above_base;
      action.recal    = action.note_off || above_recal;
      action.note_on  = !action.recal && !note_active && below_press;
   end

endmodule

// ===== rtl/light_beam_note_trigger.sv =====
`timescale 1ns / 1ps

// Light-beam note trigger. Each request is either a 10-bit sensor sample for one
// channel or a scale-button press. A sample request passes through an input register
// and a result register; samples stream at one per cycle unless a result is held back; a
// calibrating channel averages 64 samples into its baseline and gives no result.
// A button press gives one note-off per channel with the old scale, one per cycle
// unless held back, then clears all notes and steps the scale; requests behind it wait.
// A full result register that is not being taken holds back any request that
// produces a result. Configuration writes are always ready and are registered.

module light_beam_note_trigger (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbnt_pkg::REQ_TDATA_W-1:0] req_tdata,  // channel, sample, zero pad
   input  logic                             req_tuser,  // func
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lbnt_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // note_number, velocity_out,
                                                        // event_channel, zero pad
   output logic                             rsp_tuser,  // note_kind
   output logic                             rsp_tlast,  // last_event
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lbnt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lbnt_pkg::CSR_W-1:0]       csr_data
);

   localparam int SLOTS = lbnt_pkg::CH_SLOTS;
   localparam logic [lbnt_pkg::CNT_W-1:0] CNT_LAST =
      lbnt_pkg::CNT_W'((1 << lbnt_pkg::AVG_LOG2) - 1);
   localparam logic [lbnt_pkg::BTN_W-1:0] BTN_LAST = lbnt_pkg::BTN_W'(lbnt_pkg::NCH - 1);
   localparam logic [lbnt_pkg::SCALE_W-1:0] SCALE_LAST =
      lbnt_pkg::SCALE_W'(lbnt_pkg::SCALES - 1);
   localparam logic [lbnt_pkg::CH_W:0] NCH_VAL = (lbnt_pkg::CH_W + 1)'(lbnt_pkg::NCH);

   // configuration
   logic [lbnt_pkg::NOTE_W-1:0]   base_note_ff;
   logic [lbnt_pkg::VEL_W-1:0]    velocity_ff;
   logic [lbnt_pkg::MARGIN_W-1:0] press_margin_ff;
   logic [lbnt_pkg::MARGIN_W-1:0] recal_margin_ff;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   lbnt_pkg::func_type            s1_func_ff;
   logic [lbnt_pkg::CH_W-1:0]     s1_ch_ff;
   logic [lbnt_pkg::SAMPLE_W-1:0] s1_sample_ff;

   // channel state
   logic [lbnt_pkg::SAMPLE_W-1:0] baseline_ff [SLOTS];
   logic [lbnt_pkg::SAMPLE_W-1:0] baseline_in [SLOTS];
   logic [SLOTS-1:0]              note_ff, note_in;
   logic [SLOTS-1:0]              cal_ff, cal_in;
   logic [lbnt_pkg::CNT_W-1:0]    cnt_ff [SLOTS];
   logic [lbnt_pkg::CNT_W-1:0]    cnt_in [SLOTS];
   logic [lbnt_pkg::SUM_W-1:0]    sum_ff [SLOTS];
   logic [lbnt_pkg::SUM_W-1:0]    sum_in [SLOTS];
   logic [lbnt_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic [lbnt_pkg::BTN_W-1:0]    btn_idx_ff, btn_idx_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   lbnt_pkg::note_kind_type       rsp_kind_ff, rsp_kind_in;
   logic [lbnt_pkg::NOTE_W-1:0]   rsp_note_ff, rsp_note_in;
   logic [lbnt_pkg::VEL_W-1:0]    rsp_vel_ff, rsp_vel_in;
   logic [lbnt_pkg::CH_W-1:0]     rsp_ch_ff, rsp_ch_in;
   logic                          rsp_last_ff, rsp_last_in;

   lbnt_pkg::action_type          action;
   logic                          is_btn;
   logic                          present;
   logic                          sample_emit;
   logic                          out_free;
   logic                          btn_last;
   logic                          step;
   logic                          done;
   logic                          load_rsp;
   logic                          req_fire;
   logic [lbnt_pkg::SUM_W-1:0]    acc;

   lbnt_decide u_decide (
      .sample       (s1_sample_ff),
      .baseline     (baseline_ff[s1_ch_ff]),
      .note_active  (note_ff[s1_ch_ff]),
      .press_margin (press_margin_ff),
      .recal_margin (recal_margin_ff),
      .action       (action)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff    <= lbnt_pkg::BASE_NOTE_RST;
         velocity_ff     <= lbnt_pkg::VELOCITY_RST;
         press_margin_ff <= lbnt_pkg::PRESS_MARG_RST;
         recal_margin_ff <= lbnt_pkg::RECAL_MARG_RST;
      end else if (csr_valid) begin
         unique case (lbnt_pkg::csr_index_type'(csr_index))
            lbnt_pkg::CSR_BASE_NOTE:    base_note_ff    <= csr_data[lbnt_pkg::NOTE_W-1:0];
            lbnt_pkg::CSR_VELOCITY:     velocity_ff     <= csr_data[lbnt_pkg::VEL_W-1:0];
            lbnt_pkg::CSR_PRESS_MARGIN: press_margin_ff <= csr_data;
            lbnt_pkg::CSR_RECAL_MARGIN: recal_margin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      is_btn      = (s1_func_ff == lbnt_pkg::FUNC_BUTTON);
      present     = {1'b0, s1_ch_ff} < NCH_VAL;
      sample_emit = !is_btn && present && !cal_ff[s1_ch_ff] &&
                    (action.note_off || action.note_on);
      out_free    = !rsp_valid_ff || rsp_tready;
      btn_last    = (btn_idx_ff == BTN_LAST);
      step        = s1_valid_ff && (is_btn ? out_free : (!sample_emit || out_free));
      done        = step && (!is_btn || btn_last);
      load_rsp    = step && (is_btn || sample_emit);
      req_tready  = !s1_valid_ff || done;
      req_fire    = req_tvalid && req_tready;
      s1_valid_in = req_fire ? 1'b1 : (done ? 1'b0 : s1_valid_ff);

      rsp_kind_in = is_btn ? lbnt_pkg::KIND_NOTE_OFF :
                    (action.note_on ? lbnt_pkg::KIND_NOTE_ON : lbnt_pkg::KIND_NOTE_OFF);
      rsp_ch_in   = is_btn ? lbnt_pkg::CH_W'(btn_idx_ff) : s1_ch_ff;
      rsp_note_in = lbnt_pkg::note_of(base_note_ff, scale_ff, rsp_ch_in);
      rsp_vel_in  = (rsp_kind_in == lbnt_pkg::KIND_NOTE_ON) ? velocity_ff : '0;
      rsp_last_in = is_btn ? btn_last : 1'b1;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      baseline_in = baseline_ff;
      note_in     = note_ff;
      cal_in      = cal_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      scale_in    = scale_ff;
      btn_idx_in  = btn_idx_ff;
      acc         = sum_ff[s1_ch_ff] + lbnt_pkg::SUM_W'(s1_sample_ff);

      if (step && is_btn) begin
         if (btn_last) begin
            btn_idx_in = '0;
            note_in    = '0;
            scale_in   = (scale_ff == SCALE_LAST) ? '0 : scale_ff + 1'b1;
         end else begin
            btn_idx_in = btn_idx_ff + 1'b1;
         end
      end else if (step && present) begin
         if (cal_ff[s1_ch_ff]) begin
            if (cnt_ff[s1_ch_ff] == CNT_LAST) begin
               baseline_in[s1_ch_ff] = acc[lbnt_pkg::SUM_W-1:lbnt_pkg::AVG_LOG2];
               cal_in[s1_ch_ff]      = 1'b0;
               cnt_in[s1_ch_ff]      = '0;
               sum_in[s1_ch_ff]      = '0;
            end else begin
               cnt_in[s1_ch_ff] = cnt_ff[s1_ch_ff] + 1'b1;
               sum_in[s1_ch_ff] = acc;
            end
         end else begin
            if (action.note_off) begin
               note_in[s1_ch_ff] = 1'b0;
            end
            if (action.note_on) begin
               note_in[s1_ch_ff] = 1'b1;
            end
            if (action.recal) begin
               cal_in[s1_ch_ff] = 1'b1;
               cnt_in[s1_ch_ff] = '0;
               sum_in[s1_ch_ff] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         note_ff      <= '0;
         cal_ff       <= '1;
         scale_ff     <= '0;
         btn_idx_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            cnt_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         note_ff      <= note_in;
         cal_ff       <= cal_in;
         scale_ff     <= scale_in;
         btn_idx_ff   <= btn_idx_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      baseline_ff <= baseline_in;
      if (req_fire) begin
         s1_func_ff   <= lbnt_pkg::func_type'(req_tuser);
         s1_ch_ff     <= req_tdata[lbnt_pkg::REQ_CH_LSB +: lbnt_pkg::CH_W];
         s1_sample_ff <= req_tdata[lbnt_pkg::REQ_SAMPLE_LSB +: lbnt_pkg::SAMPLE_W];
      end
      if (load_rsp) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_note_ff <= rsp_note_in;
         rsp_vel_ff  <= rsp_vel_in;
         rsp_ch_ff   <= rsp_ch_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(lbnt_pkg::RSP_TDATA_W - lbnt_pkg::RSP_USED_W){1'b0}},
                        rsp_ch_ff, rsp_vel_ff, rsp_note_ff};

endmodule

// ===== rtl/lbnt_checker.sv =====
`timescale 1ns / 1ps

module lbnt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lbnt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   localparam int VL = lbnt_pkg::RSP_VEL_LSB;
   localparam int VH = lbnt_pkg::RSP_VEL_LSB + lbnt_pkg::VEL_W - 1;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // note-off carries zero velocity
   a_off_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[VH:VL] == '0)
      else $error("note-off with nonzero velocity");

   // a note-on is always the only result of its request
   a_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("note-on not marked last");

   // nothing pending straight out of reset
   a_rst_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("busy after reset");

   // padding bits of the result stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[lbnt_pkg::RSP_TDATA_W-1:lbnt_pkg::RSP_USED_W] == '0)
      else $error("result padding not zero");

endmodule

bind light_beam_note_trigger lbnt_checker u_lbnt_checker (.*);
